@@ rtl/pcc_pkg.sv @@
`default_nettype none
package pcc_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int SEG_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int SUM_W    = PROD_W + 3;

   // Divider layout: quotient bits resolved per stage, stage count
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STAGES    = PROD_W / DIV_STEP_BITS;

   localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'hffff;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_POINTS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_MUL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DIV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MUL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_DIV    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_PLUS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_MINUS = 3'd6;

   // Register reset values
   localparam logic [47:0] CUT_RESET  = 48'hffff_ffff_ffff;
   localparam logic [63:0] GAIN_RESET = 64'h03e8_03e8_03e8_03e8;

   typedef struct packed {
      logic [47:0] cut_points;
      logic [63:0] gain_mul;
      logic [63:0] gain_div;
      logic [63:0] drive_mul;
      logic [63:0] drive_div;
      logic [63:0] offset_plus;
      logic [63:0] offset_minus;
   } pcc_cfg_type;

   // After segment selection
   typedef struct packed {
      logic [SAMPLE_W-1:0]      reading;
      logic [SAMPLE_W-1:0]      drive;
      logic [SEG_W-1:0]         seg;
      logic [SAMPLE_W-1:0]      gm;
      logic [SAMPLE_W-1:0]      gd;
      logic [SAMPLE_W-1:0]      dm;
      logic [SAMPLE_W-1:0]      dd;
      logic                     gain_use;
      logic                     drive_use;
      logic signed [SAMPLE_W:0] offset;
   } pcc_sel_type;

   // One divider lane: numerator bits shift out on top, quotient bits in below
   typedef struct packed {
      logic [PROD_W-1:0]   nq;
      logic [SAMPLE_W-1:0] rem;
      logic [SAMPLE_W-1:0] dvs;
   } pcc_lane_type;

   typedef struct packed {
      pcc_lane_type             g;
      pcc_lane_type             d;
      logic [SEG_W-1:0]         seg;
      logic                     fault;
      logic signed [SAMPLE_W:0] offset;
   } pcc_div_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] current;
      logic [SEG_W-1:0]    seg;
      logic                fault;
   } pcc_rsp_type;

   function automatic logic [SAMPLE_W-1:0] slice16(input logic [63:0] r,
                                                   input logic [SEG_W-1:0] s);
      return r[s*SAMPLE_W +: SAMPLE_W];
   endfunction

   // A few restoring-division steps on one lane
   function automatic pcc_lane_type div_bits(input pcc_lane_type p);
      pcc_lane_type        q;
      logic [SAMPLE_W:0]   r;
      q = p;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r = {q.rem, q.nq[PROD_W-1]};
         q.nq = {q.nq[PROD_W-2:0], 1'b0};
         if (r >= {1'b0, q.dvs}) begin
            r = r - {1'b0, q.dvs};
            q.nq[0] = 1'b1;
         end
         q.rem = r[SAMPLE_W-1:0];
      end
      return q;
   endfunction

endpackage
`default_nettype wire

@@ rtl/pcc_if.sv @@
`default_nettype none
interface pcc_req_if;
   import pcc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_current;
   logic [SAMPLE_W-1:0] drive_value;
   modport source(output valid, raw_current, drive_value, input ready);
   modport sink(input valid, raw_current, drive_value, output ready);
endinterface

interface pcc_rsp_if;
   import pcc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] calibrated_current;
   logic [SEG_W-1:0]    segment;
   logic                divide_fault;
   modport source(output valid, calibrated_current, segment, divide_fault, input ready);
   modport sink(input valid, calibrated_current, segment, divide_fault, output ready);
endinterface

interface pcc_csr_if;
   import pcc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/pcc_csr.sv @@
`default_nettype none
module pcc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_valid,
   output logic                                wr_ready,
   input  wire logic [pcc_pkg::CSR_IDX_W-1:0]  wr_index,
   input  wire logic [pcc_pkg::CSR_DATA_W-1:0] wr_data,
   output pcc_pkg::pcc_cfg_type                cfg
);
   import pcc_pkg::*;

   pcc_cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg = cfg_ff;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            CSR_CUT_POINTS:   cfg_in.cut_points   = wr_data[47:0];
            CSR_GAIN_MUL:     cfg_in.gain_mul     = wr_data;
            CSR_GAIN_DIV:     cfg_in.gain_div     = wr_data;
            CSR_DRIVE_MUL:    cfg_in.drive_mul    = wr_data;
            CSR_DRIVE_DIV:    cfg_in.drive_div    = wr_data;
            CSR_OFFSET_PLUS:  cfg_in.offset_plus  = wr_data;
            CSR_OFFSET_MINUS: cfg_in.offset_minus = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cut_points   <= CUT_RESET;
         cfg_ff.gain_mul     <= GAIN_RESET;
         cfg_ff.gain_div     <= GAIN_RESET;
         cfg_ff.drive_mul    <= '0;
         cfg_ff.drive_div    <= '0;
         cfg_ff.offset_plus  <= '0;
         cfg_ff.offset_minus <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pcc_front.sv @@
`default_nettype none
module pcc_front #(
   parameter int SEGMENTS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcc_pkg::pcc_cfg_type         cfg,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [pcc_pkg::SAMPLE_W-1:0] reading,
   input  wire logic [pcc_pkg::SAMPLE_W-1:0] drive,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output pcc_pkg::pcc_div_type              out_data
);
   import pcc_pkg::*;

   logic        sel_valid_ff, sel_valid_in;
   pcc_sel_type sel_ff, sel_in;
   logic        sel_ready;
   logic        mul_valid_ff, mul_valid_in;
   pcc_div_type mul_ff, mul_in;
   logic [SEG_W-1:0] seg;
   logic [PROD_W-1:0] prod_g, prod_d;

   assign sel_ready = !mul_valid_ff || out_ready;
   assign in_ready  = !sel_valid_ff || sel_ready;

   // stage 1: pick the segment, the first cut point at or above the reading
   always_comb begin
      seg = SEG_W'(SEGMENTS - 1);
      for (int i = SEGMENTS - 2; i >= 0; i--) begin
         if (cfg.cut_points[i*SAMPLE_W +: SAMPLE_W] >= reading) begin
            seg = SEG_W'(i);
         end
      end
      sel_in.reading   = reading;
      sel_in.drive     = drive;
      sel_in.seg       = seg;
      sel_in.gm        = slice16(cfg.gain_mul, seg);
      sel_in.gd        = slice16(cfg.gain_div, seg);
      sel_in.dm        = slice16(cfg.drive_mul, seg);
      sel_in.dd        = slice16(cfg.drive_div, seg);
      sel_in.gain_use  = sel_in.gm != sel_in.gd;
      sel_in.drive_use = sel_in.dm != sel_in.dd;
      sel_in.offset    = $signed({1'b0, slice16(cfg.offset_plus, seg)})
                       - $signed({1'b0, slice16(cfg.offset_minus, seg)});
      sel_valid_in = in_ready ? in_valid : sel_valid_ff;
   end

   // stage 2: products; bypass and zero-divisor cases become x/1
   always_comb begin
      prod_g = sel_ff.reading * sel_ff.gm;
      prod_d = sel_ff.drive * sel_ff.dm;
      mul_in.seg    = sel_ff.seg;
      mul_in.offset = sel_ff.offset;
      mul_in.fault  = (sel_ff.gain_use && sel_ff.gd == '0)
                   || (sel_ff.drive_use && sel_ff.dd == '0);
      mul_in.g.rem  = '0;
      mul_in.d.rem  = '0;
      if (!sel_ff.gain_use) begin
         mul_in.g.nq  = PROD_W'(sel_ff.reading);
         mul_in.g.dvs = SAMPLE_W'(1);
      end else if (sel_ff.gd == '0) begin
         mul_in.g.nq  = PROD_W'(SAT_MAX);
         mul_in.g.dvs = SAMPLE_W'(1);
      end else begin
         mul_in.g.nq  = prod_g;
         mul_in.g.dvs = sel_ff.gd;
      end
      if (!sel_ff.drive_use) begin
         mul_in.d.nq  = '0;
         mul_in.d.dvs = SAMPLE_W'(1);
      end else if (sel_ff.dd == '0) begin
         mul_in.d.nq  = PROD_W'(SAT_MAX);
         mul_in.d.dvs = SAMPLE_W'(1);
      end else begin
         mul_in.d.nq  = prod_d;
         mul_in.d.dvs = sel_ff.dd;
      end
      mul_valid_in = sel_ready ? sel_valid_ff : mul_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= sel_valid_in;
         mul_valid_ff <= mul_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sel_ff <= sel_in;
      end
      if (sel_ready && sel_valid_ff) begin
         mul_ff <= mul_in;
      end
   end

   assign out_valid = mul_valid_ff;
   assign out_data  = mul_ff;

endmodule
`default_nettype wire

@@ rtl/pcc_div_step.sv @@
`default_nettype none
module pcc_div_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pcc_pkg::pcc_div_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pcc_pkg::pcc_div_type      out_data
);
   import pcc_pkg::*;

   logic        valid_ff, valid_in;
   pcc_div_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   // both lanes advance by the same number of quotient bits
   always_comb begin
      data_in   = in_data;
      data_in.g = div_bits(in_data.g);
      data_in.d = div_bits(in_data.d);
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // partial remainders stay below a nonzero divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.g.rem < data_ff.g.dvs) && (data_ff.d.rem < data_ff.d.dvs))
      else $error("partial remainder not below divisor");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.g.dvs != '0) && (data_ff.d.dvs != '0))
      else $error("zero divisor reached the divider");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stalled divider stage changed");

endmodule
`default_nettype wire

@@ rtl/pcc_back.sv @@
`default_nettype none
module pcc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pcc_pkg::pcc_div_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pcc_pkg::pcc_rsp_type      out_data
);
   import pcc_pkg::*;

   logic              valid_ff, valid_in;
   pcc_rsp_type       data_ff, data_in;
   logic signed [SUM_W-1:0] sum;

   assign in_ready = !valid_ff || out_ready;

   // gain term minus drive term plus offset, clamped to 16 bits
   always_comb begin
      sum = $signed({3'b000, in_data.g.nq}) - $signed({3'b000, in_data.d.nq})
          + SUM_W'($signed(in_data.offset));
      if (sum > $signed(SUM_W'(SAT_MAX))) begin
         data_in.current = SAT_MAX;
      end else if (sum < 0) begin
         data_in.current = '0;
      end else begin
         data_in.current = sum[SAMPLE_W-1:0];
      end
      data_in.seg   = in_data.seg;
      data_in.fault = in_data.fault;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ rtl/piecewise_current_calibration.sv @@
// Channel   Dir   Fields                                        Accepted when
// req_ch    in    raw_current[16], drive_value[16]              valid && ready
// rsp_ch    out   calibrated_current[16], segment[2], fault[1]  valid && ready
// csr_ch    in    index[3], data[64]                            valid && ready
//
// One request per cycle sustained while the response channel keeps accepting results.
// Stages: segment select, multiply, 8 divider stages of 4 quotient bits each
// (32-bit quotient, set by the restoring divider), then combine and clamp.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage holds while the next one is full and stalled; bubbles are squeezed out.
// The configuration port never stalls.
`default_nettype none
module piecewise_current_calibration #(
   parameter int SEGMENTS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   pcc_req_if.sink   req_ch,
   pcc_rsp_if.source rsp_ch,
   pcc_csr_if.sink   csr_ch
);
   import pcc_pkg::*;

   pcc_cfg_type cfg;
   pcc_rsp_type rsp_data;
   logic        div_valid [DIV_STAGES+1];
   logic        div_ready [DIV_STAGES+1];
   pcc_div_type div_data  [DIV_STAGES+1];

   // configuration registers
   pcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // segment select and products
   pcc_front #(.SEGMENTS(SEGMENTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .reading   (req_ch.raw_current),
      .drive     (req_ch.drive_value),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // pipelined divider chain
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      pcc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   // combine, clamp and hold the result
   pcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DIV_STAGES]),
      .in_ready  (div_ready[DIV_STAGES]),
      .in_data   (div_data[DIV_STAGES]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.calibrated_current = rsp_data.current;
   assign rsp_ch.segment            = rsp_data.seg;
   assign rsp_ch.divide_fault       = rsp_data.fault;

endmodule
`default_nettype wire
